// File: sv/flhs_pkg.sv
`default_nettype none
package flhs_pkg;

	// store geometry
	localparam int CAPACITY   = 1024;
	localparam int VALUE_BITS = 64;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int PTR_W      = $clog2(CAPACITY + 1);

	// beat fields
	localparam int FUNC_W   = 3;
	localparam int HANDLE_W = 16;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;
	localparam int HOUT_W   = 17;
	localparam int COUNT_W  = 17;

	// input beat layout
	localparam int IN_FUNC_LSB   = 0;
	localparam int IN_HANDLE_LSB = IN_FUNC_LSB + FUNC_W;
	localparam int IN_VALUE_LSB  = IN_HANDLE_LSB + HANDLE_W;
	localparam int IN_START_LSB  = IN_VALUE_LSB + VALUE_W;
	localparam int IN_USED_W     = IN_START_LSB + 1;
	localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

	// output beat layout
	localparam int OUT_USED_W  = STATUS_W + HOUT_W + VALUE_W + COUNT_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// request codes
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BLANK = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic sweep;
		logic exec;
	} flhs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_is_clear;
		logic sweep_last;
		logic out_free;
	} flhs_stat_t;

endpackage
`default_nettype wire

// File: sv/flhs_ram.sv
`default_nettype none
module flhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: sv/flhs_ctrl.sv
`default_nettype none
module flhs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire flhs_pkg::flhs_stat_t stat,
	output flhs_pkg::flhs_cmd_t     cmd
);

	import flhs_pkg::*;

	typedef enum logic [3:0] {
		S_INIT  = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_EXEC  = 4'b1000
	} state_t;

	state_t state_q, state_n;

	// next state and commands
	always_comb begin
		state_n    = state_q;
		cmd.accept = 1'b0;
		cmd.sweep  = 1'b0;
		cmd.exec   = 1'b0;
		s_tready   = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_n    = stat.in_is_clear ? S_SWEEP : S_EXEC;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_n  = S_IDLE;
				end
			end
			default: begin
				state_n = S_INIT;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sweep && s_tready)) else $error("beat taken during sweep");
	a_exec_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> stat.out_free) else $error("result would overwrite pending beat");
	a_accept_then_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (cmd.sweep || state_q == S_EXEC)) else $error("accepted beat dropped");

endmodule
`default_nettype wire

// File: sv/flhs_dp.sv
`default_nettype none
module flhs_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [flhs_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [flhs_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  wire flhs_pkg::flhs_cmd_t               cmd,
	output flhs_pkg::flhs_stat_t                   stat
);

	import flhs_pkg::*;

	// input beat fields
	logic [FUNC_W-1:0]     in_func;
	logic [HANDLE_W-1:0]   in_handle;
	logic [VALUE_BITS-1:0] in_value;
	logic                  in_start;

	// captured request
	logic [FUNC_W-1:0]     func_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  start_q;

	// store state
	logic [PTR_W-1:0] head_q, head_n;
	logic [PTR_W-1:0] occ_q, occ_n;
	logic [IDX_W-1:0] cnt_q;

	// memory ports
	logic [IDX_W-1:0]      rd_addr;
	logic                  link_we;
	logic [IDX_W-1:0]      link_waddr;
	logic [PTR_W:0]        link_wdata;
	logic [PTR_W:0]        link_rdata;
	logic                  val_we;
	logic                  x_link_we;
	logic [IDX_W-1:0]      x_link_waddr;
	logic [PTR_W:0]        x_link_wdata;
	logic [VALUE_BITS-1:0] val_rdata;

	// result of the current request
	logic [STATUS_W-1:0]   status_n;
	logic [HOUT_W-1:0]     hout_n;
	logic [VALUE_BITS-1:0] vout_n;
	logic                  h_in_range;
	logic                  rd_live;
	logic [PTR_W-1:0]      rd_next;

	// output register
	logic                  m_tvalid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [HOUT_W-1:0]     hout_q;
	logic [VALUE_BITS-1:0] vout_q;
	logic [PTR_W-1:0]      count_q;

	// unpack the input beat
	assign in_func   = s_tdata[IN_FUNC_LSB +: FUNC_W];
	assign in_handle = s_tdata[IN_HANDLE_LSB +: HANDLE_W];
	assign in_value  = s_tdata[IN_VALUE_LSB +: VALUE_BITS];
	assign in_start  = s_tdata[IN_START_LSB];

	// insert reads the head slot, the others read the given slot
	assign rd_addr = (in_func == FN_INSERT) ? head_q[IDX_W-1:0] : in_handle[IDX_W-1:0];

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q   <= in_func;
			handle_q <= in_handle;
			value_q  <= in_value;
			start_q  <= in_start;
		end
	end

	// link memory: live flag over next pointer
	flhs_ram #(
		.WIDTH (PTR_W + 1),
		.DEPTH (CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (cmd.accept),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	// slot values
	flhs_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we & cmd.exec),
		.waddr (head_q[IDX_W-1:0]),
		.wdata (value_q),
		.re    (cmd.accept),
		.raddr (in_handle[IDX_W-1:0]),
		.rdata (val_rdata)
	);

	assign rd_live    = link_rdata[PTR_W];
	assign rd_next    = link_rdata[PTR_W-1:0];
	assign h_in_range = {1'b0, handle_q} < HOUT_W'(CAPACITY);

	// request execution
	always_comb begin
		status_n     = ST_OK;
		hout_n       = '0;
		vout_n       = '0;
		head_n       = head_q;
		occ_n        = occ_q;
		x_link_we    = 1'b0;
		x_link_waddr = handle_q[IDX_W-1:0];
		x_link_wdata = {1'b0, head_q};
		val_we       = 1'b0;
		case (func_q)
			FN_INSERT: begin
				if (occ_q >= PTR_W'(CAPACITY) || head_q >= PTR_W'(CAPACITY)) begin
					status_n = ST_FULL;
				end else begin
					x_link_we    = 1'b1;
					x_link_waddr = head_q[IDX_W-1:0];
					x_link_wdata = {1'b1, rd_next};
					val_we       = 1'b1;
					head_n       = rd_next;
					occ_n        = occ_q + PTR_W'(1);
					hout_n       = HOUT_W'(head_q);
				end
			end
			FN_REMOVE: begin
				if (!(h_in_range && rd_live)) begin
					status_n = ST_BLANK;
				end else begin
					x_link_we = 1'b1;
					head_n    = PTR_W'(handle_q[IDX_W-1:0]);
					if (occ_q != '0) begin
						occ_n = occ_q - PTR_W'(1);
					end
				end
			end
			FN_READ: begin
				if (!(h_in_range && rd_live)) begin
					status_n = ST_BLANK;
				end else begin
					vout_n = val_rdata;
				end
			end
			FN_CLEAR: begin
				head_n = '0;
				occ_n  = '0;
			end
			FN_NEXT: begin
				if (start_q) begin
					hout_n = HOUT_W'(head_q);
				end else if (!h_in_range) begin
					hout_n = {1'b0, handle_q} + HOUT_W'(1);
				end else if (rd_live) begin
					status_n = ST_BLANK;
				end else begin
					hout_n = HOUT_W'(rd_next);
				end
			end
			default: begin
				status_n = ST_OK;
			end
		endcase
	end

	// sweep writes blank slots chained to the next index
	always_comb begin
		if (cmd.sweep) begin
			link_we    = 1'b1;
			link_waddr = cnt_q;
			link_wdata = {1'b0, PTR_W'(cnt_q) + PTR_W'(1)};
		end else begin
			link_we    = cmd.exec & x_link_we;
			link_waddr = x_link_waddr;
			link_wdata = x_link_wdata;
		end
	end

	assign stat.sweep_last  = (cnt_q == IDX_W'(CAPACITY - 1));
	assign stat.in_is_clear = (in_func == FN_CLEAR);
	assign stat.out_free    = !m_tvalid_q || m_tready;

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.sweep) begin
			cnt_q <= stat.sweep_last ? '0 : cnt_q + IDX_W'(1);
		end
	end

	// free list head and live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (cmd.exec) begin
			head_q <= head_n;
			occ_q  <= occ_n;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.exec) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_n;
			hout_q   <= hout_n;
			vout_q   <= vout_n;
			count_q  <= occ_n;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'({COUNT_W'(count_q), VALUE_W'(vout_q), hout_q, status_q});

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= PTR_W'(CAPACITY)) else $error("live count above capacity");
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= PTR_W'(CAPACITY)) else $error("free head out of range");
	a_valid_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(cmd.exec)) else $error("result beat without request");

endmodule
`default_nettype wire

// File: sv/free_list_handle_store.sv
// sequencing: a request is captured together with its slot reads when accepted, executed
// in the execute state, and its result beat then waits in an output register; a pending
// result beat holds the next request in its execute state until the sink takes it.
// one request is handled at a time: s_tready is high only in the idle state, so no new request
// is taken before the last one has executed; a clear request first sweeps the slot link memory.
// reset: asynchronous, active low; after release a clearing pass rebuilds the free chain
// with s_tready low, and values stay undefined until written.
`default_nettype none
module free_list_handle_store (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// func[2:0], handle[18:3], value[82:19], from_start[83], zero pad
	input  wire logic [flhs_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// status[1:0], handle_out[18:2], value_out[82:19], live_count[99:83], zero pad
	output logic      [flhs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	import flhs_pkg::*;

	flhs_cmd_t  cmd;
	flhs_stat_t stat;

	// request sequencing
	flhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// slot memories, free list head and result register
	flhs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
`default_nettype wire
